[rtl/ptp_pkg.sv]
// Shared types and constants for the perspective point transform.
package ptp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FIX_W     = 32;
    localparam int CFG_W     = 64;
    localparam int N_REGS    = 8;
    localparam int CFG_IDX_W = 4;
    localparam int REG_SEL_W = 3;
    localparam int PROD_W    = 2 * FIX_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int ROW_W     = SUM_W - FRAC_BITS + 1;
    localparam int MAG_W     = ROW_W;
    localparam int NUM_W     = MAG_W + FRAC_BITS;
    localparam int Q_W       = FIX_W + 1;
    localparam int QD        = 8;
    localparam int QPTR_W    = 3;
    localparam int QCNT_W    = 4;
    localparam int LATENCY   = Q_W + 6;

    localparam logic [CFG_W-1:0] ONE_FX = CFG_W'(1) << FRAC_BITS;
    localparam logic [CFG_W-1:0] CFG_RST [N_REGS] = '{
        ONE_FX, '0, ONE_FX << 32, '0, '0, ONE_FX, '0, ONE_FX << 32
    };

    localparam logic signed [FIX_W-1:0] FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};
    localparam logic signed [FIX_W-1:0] FIX_MIN = {1'b1, {(FIX_W-1){1'b0}}};
    localparam logic [Q_W-1:0] LIM_POS = Q_W'(FIX_MAX);
    localparam logic [Q_W-1:0] LIM_NEG = LIM_POS + Q_W'(1);

    typedef struct packed {
        logic signed [FIX_W-1:0] point_x;
        logic signed [FIX_W-1:0] point_y;
        logic signed [FIX_W-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [FIX_W-1:0] proj_x;
        logic signed [FIX_W-1:0] proj_y;
        logic signed [FIX_W-1:0] proj_z;
        logic                    saturated;
    } t_result;

    typedef struct packed {
        logic [MAG_W-1:0] mag_n;
        logic [MAG_W-1:0] mag_d;
        logic             neg;
        logic             n_neg;
        logic             nz;
        logic             dz;
    } t_div_in;

    typedef struct packed {
        t_div_in [2:0] lane;
    } t_qentry;

    typedef struct packed {
        logic signed [FIX_W-1:0] value;
        logic                    sat;
    } t_div_out;

    function automatic logic signed [FIX_W-1:0] cfg_half(input logic [CFG_W-1:0] v,
                                                         input logic hi);
        cfg_half = hi ? $signed(v[CFG_W-1:FIX_W]) : $signed(v[FIX_W-1:0]);
    endfunction

endpackage

[rtl/ptp_front.sv]
// Front end: matrix registers, products, row sums and divide classification.
module ptp_front import ptp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_point               i_point,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_pop,
    output logic                 o_push,
    output t_qentry              o_entry
);

    logic [CFG_W-1:0]        r_cfg [N_REGS];
    logic                    r_v0, r_v1, r_v2;
    logic [QCNT_W-1:0]       r_held;
    t_point                  r_pt;
    logic signed [PROD_W-1:0] r_prod [4][3];
    logic signed [ROW_W-1:0]  r_row [4];
    logic signed [FIX_W-1:0]  pv [3];
    logic signed [SUM_W-1:0]  sum [4];
    logic                    acc;

    assign acc  = start && !busy;
    assign busy = (r_held == QCNT_W'(QD));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_REGS; k++) r_cfg[k] <= CFG_RST[k];
        end else if (i_cfg_we && i_cfg_idx < CFG_IDX_W'(N_REGS)) begin
            r_cfg[i_cfg_idx[REG_SEL_W-1:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_held <= '0;
        end else begin
            r_v0   <= acc;
            r_v1   <= r_v0;
            r_v2   <= r_v1;
            r_held <= r_held + QCNT_W'(acc) - QCNT_W'(i_pop);
        end
    end

    assign pv[0] = r_pt.point_x;
    assign pv[1] = r_pt.point_y;
    assign pv[2] = r_pt.point_z;

    always_ff @(posedge i_clk) begin
        if (acc) r_pt <= i_point;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[r][c] <= PROD_W'(cfg_half(r_cfg[c*2 + r/2], 1'(r % 2)))
                              * PROD_W'(pv[c]);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            sum[r] = SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1]) + SUM_W'(r_prod[r][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            r_row[r] <= ROW_W'(sum[r] >>> FRAC_BITS)
                      + ROW_W'(cfg_half(r_cfg[6 + r/2], 1'(r % 2)));
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_entry.lane[k].mag_n = r_row[k][ROW_W-1] ? MAG_W'(-r_row[k]) : MAG_W'(r_row[k]);
            o_entry.lane[k].mag_d = r_row[3][ROW_W-1] ? MAG_W'(-r_row[3]) : MAG_W'(r_row[3]);
            o_entry.lane[k].n_neg = r_row[k][ROW_W-1];
            o_entry.lane[k].neg   = r_row[k][ROW_W-1] ^ r_row[3][ROW_W-1];
            o_entry.lane[k].nz    = (r_row[k] != '0);
            o_entry.lane[k].dz    = (r_row[3] == '0);
        end
    end

    assign o_push = r_v2;

endmodule

[rtl/ptp_queue.sv]
// Short queue between front and back ends.
module ptp_queue import ptp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_qentry i_entry,
    output logic    o_pop,
    output t_qentry o_entry
);

    t_qentry           r_mem [QD];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_pop   = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_W'(1);
            if (o_pop)  r_rd <= r_rd + QPTR_W'(1);
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(o_pop);
        end
    end

endmodule

[rtl/ptp_div.sv]
// Pipelined restoring divider with saturation, one quotient bit per stage.
module ptp_div import ptp_pkg::*; (
    input  logic     i_clk,
    input  t_div_in  i_in,
    output t_div_out o_out
);

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] d;
        logic [Q_W-1:0]   nlow;
        logic [Q_W-1:0]   q;
        logic             neg;
        logic             n_neg;
        logic             nz;
        logic             dz;
        logic             ovf;
    } t_stage;

    t_stage           r_stg [Q_W+1];
    t_stage           n_stg [Q_W+1];
    logic [NUM_W-1:0] num;
    logic [MAG_W-1:0] rem0;

    assign num  = {i_in.mag_n, {FRAC_BITS{1'b0}}};
    assign rem0 = MAG_W'(num >> Q_W);

    always_comb begin
        logic [MAG_W:0] trial;
        n_stg[0].rem   = rem0;
        n_stg[0].d     = i_in.mag_d;
        n_stg[0].nlow  = num[Q_W-1:0];
        n_stg[0].q     = '0;
        n_stg[0].neg   = i_in.neg;
        n_stg[0].n_neg = i_in.n_neg;
        n_stg[0].nz    = i_in.nz;
        n_stg[0].dz    = i_in.dz;
        n_stg[0].ovf   = (rem0 >= i_in.mag_d);
        for (int i = 0; i < Q_W; i++) begin
            trial      = {r_stg[i].rem, r_stg[i].nlow[Q_W-1-i]};
            n_stg[i+1] = r_stg[i];
            if (trial >= {1'b0, r_stg[i].d}) begin
                n_stg[i+1].rem = MAG_W'(trial - {1'b0, r_stg[i].d});
                n_stg[i+1].q   = {r_stg[i].q[Q_W-2:0], 1'b1};
            end else begin
                n_stg[i+1].rem = MAG_W'(trial);
                n_stg[i+1].q   = {r_stg[i].q[Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_stg <= n_stg;
    end

    always_comb begin
        if (r_stg[Q_W].dz) begin
            o_out.sat   = 1'b1;
            o_out.value = !r_stg[Q_W].nz ? '0 : (r_stg[Q_W].n_neg ? FIX_MIN : FIX_MAX);
        end else if (r_stg[Q_W].ovf
                     || r_stg[Q_W].q > (r_stg[Q_W].neg ? LIM_NEG : LIM_POS)) begin
            o_out.sat   = 1'b1;
            o_out.value = r_stg[Q_W].neg ? FIX_MIN : FIX_MAX;
        end else begin
            o_out.sat   = 1'b0;
            o_out.value = r_stg[Q_W].neg ? -$signed(r_stg[Q_W].q[FIX_W-1:0])
                                         : $signed(r_stg[Q_W].q[FIX_W-1:0]);
        end
    end

endmodule

[rtl/ptp_back.sv]
// Back end: three divider lanes and the result register.
module ptp_back import ptp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_take,
    input  t_qentry i_entry,
    output logic    o_valid,
    output t_result o_result
);

    logic     r_vld [Q_W+1];
    t_div_out dout [3];

    for (genvar k = 0; k < 3; k++) begin : g_lane
        ptp_div u_div (
            .i_clk (i_clk),
            .i_in  (i_entry.lane[k]),
            .o_out (dout[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= Q_W; s++) r_vld[s] <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_vld[0] <= i_take;
            for (int s = 1; s <= Q_W; s++) r_vld[s] <= r_vld[s-1];
            o_valid <= r_vld[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        o_result.proj_x    <= dout[0].value;
        o_result.proj_y    <= dout[1].value;
        o_result.proj_z    <= dout[2].value;
        o_result.saturated <= dout[0].sat | dout[1].sat | dout[2].sat;
    end

endmodule

[rtl/point_transform_perspective.sv]
// Top level: 4x4 homogeneous point transform with perspective divide.
// Path: an accepted beat's result is strobed on o_valid from the output register.
// Throughput: one point per cycle; 3 front stages, the queue, the divider stages, output reg.
// busy stays low: the back end takes a beat every cycle, so the queue never fills.
// Synchronous active-low reset clears all valids and loads the identity matrix.
// The receiver cannot stall; each result is on o_result for one cycle.
module point_transform_perspective import ptp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_point               i_point,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    output t_result              o_result
);

    logic    push, pop;
    t_qentry f_entry, q_entry;

    ptp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_point    (i_point),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pop      (pop),
        .o_push     (push),
        .o_entry    (f_entry)
    );

    ptp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .o_pop   (pop),
        .o_entry (q_entry)
    );

    ptp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (pop),
        .i_entry  (q_entry),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

[rtl/ptp_check.sv]
// Port-level checks for the perspective point transform.
module ptp_check import ptp_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> !busy)
        else $error("busy after reset");

    a_rst_vld: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("result missing at fixed latency");

    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without accepted beat");

endmodule

bind point_transform_perspective ptp_check u_chk (.*);

[tb/ptp_checker.sv]
// Checker for the point transform: predicts each projected point and compares results.
module ptp_checker import ptp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_point               i_point,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    input  t_result              i_result,
    output int                   o_fail_cnt,
    output int                   o_pending,
    output int                   o_sat_cnt
);

    logic [CFG_W-1:0] matrix [N_REGS];
    t_result          proj_q [$];

    function automatic logic signed [FIX_W-1:0] mat_entry(int col, int row);
        logic [CFG_W-1:0] r;
        r = matrix[(col * 2 + row / 2) % N_REGS];
        return (row % 2) ? r[CFG_W-1:FIX_W] : r[FIX_W-1:0];
    endfunction

    function automatic logic signed [127:0] row_total(int row, t_point p);
        logic signed [127:0] s, e, c;
        s = '0;
        for (int k = 0; k < 3; k++) begin
            e = mat_entry(k, row);
            c = (k == 0) ? p.point_x : (k == 1) ? p.point_y : p.point_z;
            s += e * c;
        end
        e = mat_entry(3, row);
        return (s >>> FRAC_BITS) + e;
    endfunction

    function automatic logic signed [FIX_W-1:0] div_sat(logic signed [127:0] num,
                                                        logic signed [127:0] den,
                                                        inout logic flag);
        logic        neg;
        logic [127:0] un, ud, mag, lim;
        if (den == 0) begin
            flag = 1'b1;
            if (num > 0) return FIX_MAX;
            if (num < 0) return FIX_MIN;
            return '0;
        end
        neg = (num < 0) != (den < 0);
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? -den : den;
        mag = (un << FRAC_BITS) / ud;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (mag > lim) begin
            flag = 1'b1;
            return neg ? FIX_MIN : FIX_MAX;
        end
        return neg ? -mag[FIX_W-1:0] : mag[FIX_W-1:0];
    endfunction

    function automatic t_result project(t_point p);
        t_result             r;
        logic signed [127:0] w;
        logic                f;
        f = 1'b0;
        w = row_total(3, p);
        r.proj_x = div_sat(row_total(0, p), w, f);
        r.proj_y = div_sat(row_total(1, p), w, f);
        r.proj_z = div_sat(row_total(2, p), w, f);
        r.saturated = f;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < N_REGS; i++) matrix[i] = CFG_RST[i];
            proj_q.delete();
            o_fail_cnt = 0;
            o_sat_cnt  = 0;
            o_pending  = 0;
        end else begin
            if (i_valid) begin
                if (proj_q.size() == 0) begin
                    o_fail_cnt++;
                    $display("%0t: unexpected result %h", $time, i_result);
                end else begin
                    exp_r = proj_q.pop_front();
                    if (exp_r.saturated) o_sat_cnt++;
                    if (exp_r.proj_x !== i_result.proj_x ||
                        exp_r.proj_y !== i_result.proj_y ||
                        exp_r.proj_z !== i_result.proj_z ||
                        exp_r.saturated !== i_result.saturated) begin
                        o_fail_cnt++;
                        $display({"%0t: mismatch exp x=%h y=%h z=%h sat=%b",
                                  " act x=%h y=%h z=%h sat=%b"},
                                 $time, exp_r.proj_x, exp_r.proj_y, exp_r.proj_z,
                                 exp_r.saturated, i_result.proj_x, i_result.proj_y,
                                 i_result.proj_z, i_result.saturated);
                    end
                end
            end
            if (i_start && !i_busy) proj_q.push_back(project(i_point));
            if (i_cfg_we && i_cfg_idx < N_REGS)
                matrix[i_cfg_idx[REG_SEL_W-1:0]] = i_cfg_data;
            o_pending = proj_q.size();
        end
    end

endmodule

[tb/testbench.sv]
// Testbench top: drives points and matrix writes into the point transform and reports.
module testbench;
    import ptp_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_point               i_point = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_valid;
    t_result              o_result;
    int                   fail_cnt, pending, sat_cnt;
    int                   n_points, n_writes, burst;

    localparam logic [FIX_W-1:0] ONE = 32'h0001_0000;
    localparam logic [FIX_W-1:0] NEG_ONE = 32'hFFFF_0000;

    always #1 i_clk = ~i_clk;

    point_transform_perspective i_dut (.*);

    ptp_checker i_chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_point,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_valid(o_valid), .i_result(o_result),
        .o_fail_cnt(fail_cnt), .o_pending(pending), .o_sat_cnt(sat_cnt)
    );

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [FIX_W-1:0] rand_fix();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return FIX_MAX;
            2:       return FIX_MIN;
            3:       return $urandom_range(0, 1) ? ONE : NEG_ONE;
            default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        endcase
    endfunction

    task automatic send_point(logic [FIX_W-1:0] x, logic [FIX_W-1:0] y,
                              logic [FIX_W-1:0] z);
        @(negedge i_clk);
        i_point = '{x, y, z};
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        n_points++;
        if (burst > 0) burst--;
        if (burst == 0) begin
            burst = $urandom_range(1, 30);
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) begin
                @(negedge i_clk);
                start = 1'b0;
            end
        end
    endtask

    task automatic write_reg(int idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        start = 1'b0;
        i_cfg_we = 1'b1;
        i_cfg_idx = CFG_IDX_W'(idx);
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        n_writes++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        wait (pending == 0);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    initial begin
        n_points = 0;
        n_writes = 0;
        burst = 5;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // identity matrix
        send_point('0, '0, '0);
        send_point(FIX_MAX, FIX_MAX, FIX_MAX);
        send_point(FIX_MIN, FIX_MIN, FIX_MIN);
        send_point(FIX_MAX, FIX_MIN, ONE);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, NEG_ONE);
        send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
        drain();

        // perspective: w = -z, zero w at z = 0
        write_reg(0, {32'h0, ONE});
        write_reg(1, 64'h0);
        write_reg(2, {ONE, 32'h0});
        write_reg(3, 64'h0);
        write_reg(4, 64'h0);
        write_reg(5, {NEG_ONE, ONE});
        write_reg(6, 64'h0);
        write_reg(7, 64'h0);
        write_reg(9, 64'hFFFF_FFFF_FFFF_FFFF);
        send_point(ONE, NEG_ONE, '0);
        send_point('0, '0, '0);
        send_point(NEG_ONE, ONE, '0);
        send_point(FIX_MAX, FIX_MIN, 32'h0000_0001);
        send_point(ONE, ONE, 32'hFFFF_FFFF);
        send_point(32'h0003_0000, 32'hFFFE_0000, NEG_ONE);
        send_point(32'h0003_0000, 32'hFFFE_0000, 32'h0004_0000);
        send_point(FIX_MAX, FIX_MAX, FIX_MIN);
        drain();

        // extreme matrices
        for (int m = 0; m < 2; m++) begin
            for (int i = 0; i < N_REGS; i++)
                write_reg(i, m ? {FIX_MIN, FIX_MIN} : {FIX_MAX, FIX_MIN});
            send_point(FIX_MAX, FIX_MAX, FIX_MAX);
            send_point(FIX_MIN, FIX_MIN, FIX_MIN);
            send_point(FIX_MIN, FIX_MAX, '0);
            send_point('0, '0, '0);
            drain();
        end

        // random matrices
        for (int ph = 0; ph < 8; ph++) begin
            for (int i = 0; i < N_REGS; i++)
                write_reg(i, {rand_fix(), rand_fix()});
            if ($urandom_range(0, 1))
                write_reg(7, {$urandom_range(0, 1) ? ONE : 32'($urandom()), 32'h0});
            write_reg($urandom_range(N_REGS, 15), {$urandom(), $urandom()});
            repeat (170) send_point(rand_fix(), rand_fix(), rand_fix());
            drain();
        end

        $display("Sent %0d points over 12 matrix settings with %0d register writes;",
                 n_points, n_writes);
        $display("%0d results were expected to saturate.", sat_cnt);
        if (fail_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
